[design/rcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the repetition counter and scorer.
// ---------------------------------------------------------------------------
package rcs_pkg;

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_STOP   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_WAIT = 2'd1,
		PH_MOVE = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	localparam logic [2:0] REG_ACTION       = 3'd0;
	localparam logic [2:0] REG_TARGET_REPS  = 3'd1;
	localparam logic [2:0] REG_ENTER_ANGLE  = 3'd2;
	localparam logic [2:0] REG_EXIT_ANGLE   = 3'd3;
	localparam logic [2:0] REG_TARGET_ANGLE = 3'd4;

	localparam logic [15:0] DEF_TARGET_REPS  = 16'd5;
	localparam logic [15:0] DEF_TARGET_ANGLE = 16'd15000;
	localparam logic [14:0] DEF_ENTER_ANGLE  = 15'd3000;
	localparam logic [15:0] DEF_EXIT_ANGLE   = 16'd3000;

	localparam int COUNT_W = 16;
	localparam int PEAK_W  = 15;
	localparam int TOTAL_W = 31;
	localparam int SCORE_W = 7;
	localparam int DIV_W   = 32;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_UPDATE,
		CTL_DIV_MEAN,
		CTL_DIV_COMP,
		CTL_DIV_AMP,
		CTL_DIV_PART,
		CTL_TOTAL,
		CTL_OUT
	} ctl_state_t;

	typedef enum logic [1:0] {
		DSEL_MEAN = 2'd0,
		DSEL_COMP = 2'd1,
		DSEL_AMP  = 2'd2,
		DSEL_PART = 2'd3
	} dsel_t;

	typedef struct packed {
		logic  update;
		logic  div_start;
		dsel_t div_sel;
		logic  div_store;
		logic  total;
		logic  out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic scores_needed;
		logic mean_needed;
		logic div_busy;
	} ctl_status_t;

endpackage
`default_nettype wire

[design/rcs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rcs_div
	import rcs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  busy,
	output logic      [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W:0]   trial;

	assign trial = {rem_q, quo_q[DIV_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[DIV_W]) begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-2:0], quo_q[DIV_W-1]};
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule
`default_nettype wire

[design/rcs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_datapath
// Session registers, repetition tracking, score division and result register.
// ---------------------------------------------------------------------------
module rcs_datapath
	import rcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	output ctl_status_t      status,
	input  wire logic        in_ready,
	input  wire logic        in_valid,
	input  wire logic [1:0]  func,
	input  wire logic        sample_valid,
	input  wire logic [1:0]  sample_action,
	input  wire logic [15:0] angle,
	input  wire logic        muscle_on,
	input  wire logic        cfg_fire,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic      [15:0] rep_count,
	output logic      [15:0] current_angle,
	output logic      [14:0] rep_peak,
	output logic      [14:0] best_peak,
	output logic      [14:0] mean_peak,
	output logic      [6:0]  reps_pct,
	output logic      [6:0]  ampl_pct,
	output logic      [6:0]  emg_pct,
	output logic      [6:0]  overall_pct,
	output logic      [1:0]  phase,
	output logic             rep_done,
	output logic             session_done
);

	localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
	// 5243 / 2^19 is close enough to 1/100 for sums up to 10000
	localparam logic [26:0] DIV100_RECIP = 27'd5243;

	// configuration registers
	logic [1:0]  cfg_action_q;
	logic [15:0] cfg_reps_q;
	logic [14:0] cfg_enter_q;
	logic [15:0] cfg_exit_q;
	logic [15:0] cfg_tang_q;
	// session copy
	logic [1:0]  ses_action_q;
	logic [15:0] ses_reps_q;
	logic [14:0] ses_enter_q;
	logic [15:0] ses_exit_q;
	logic [15:0] ses_tang_q;
	// state
	phase_t                 phase_q;
	logic [COUNT_W-1:0]     reps_q;
	logic [PEAK_W-1:0]      peak_now_q;
	logic [PEAK_W-1:0]      peak_best_q;
	logic [TOTAL_W-1:0]     peak_total_q;
	logic [PEAK_W-1:0]      mean_q;
	logic [COUNT_W-1:0]     emg_reps_q;
	logic                   had_emg_q;
	logic [15:0]            shown_q;
	logic [SCORE_W-1:0]     comp_q, amp_q, part_q, tot_q;
	logic                   rep_done_q, sess_done_q;
	// latched request
	logic [1:0]  func_q;
	logic        sv_q;
	logic [1:0]  act_q;
	logic [15:0] ang_q;
	logic        emg_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q <= func;
			sv_q   <= sample_valid;
			act_q  <= sample_action;
			ang_q  <= angle;
			emg_q  <= muscle_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_action_q <= '0;
			cfg_reps_q   <= DEF_TARGET_REPS;
			cfg_enter_q  <= DEF_ENTER_ANGLE;
			cfg_exit_q   <= DEF_EXIT_ANGLE;
			cfg_tang_q   <= DEF_TARGET_ANGLE;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_ACTION:       cfg_action_q <= cfg_data[1:0];
				REG_TARGET_REPS:  cfg_reps_q   <= cfg_data;
				REG_ENTER_ANGLE:  cfg_enter_q  <= cfg_data[14:0];
				REG_EXIT_ANGLE:   cfg_exit_q   <= cfg_data;
				REG_TARGET_ANGLE: cfg_tang_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample decode
	logic signed [16:0] ang_s, enter_s, exit_s, peak_s;
	logic               is_live, counted, enter_hit, exit_hit;
	logic [COUNT_W-1:0] reps_inc;
	logic [TOTAL_W:0]   total_sum;
	logic signed [16:0] cfg_exit_s, cfg_enter_s;

	assign ang_s       = {ang_q[15], ang_q};
	assign enter_s     = {2'b00, ses_enter_q};
	assign exit_s      = {ses_exit_q[15], ses_exit_q};
	assign peak_s      = {2'b00, peak_now_q};
	assign is_live     = (phase_q == PH_WAIT) || (phase_q == PH_MOVE);
	assign counted     = sv_q && (act_q == ses_action_q);
	assign enter_hit   = ang_s >= enter_s;
	assign exit_hit    = ang_s <= exit_s;
	assign reps_inc    = (reps_q != CNT_MAX) ? reps_q + 1'b1 : reps_q;
	assign total_sum   = {1'b0, peak_total_q} + (TOTAL_W + 1)'(peak_now_q);
	assign cfg_exit_s  = {cfg_exit_q[15], cfg_exit_q};
	assign cfg_enter_s = {2'b00, cfg_enter_q};

	// divider
	logic [DIV_W-1:0] dv_a, dv_b, dv_q;
	logic             dv_busy;
	logic [DIV_W-1:0] pct_num;
	logic [SCORE_W-1:0] pct_clamped;

	always_comb begin
		dv_a = '0;
		dv_b = 32'd1;
		unique case (cmd.div_sel)
			DSEL_MEAN: begin
				dv_a = DIV_W'(peak_total_q);
				dv_b = DIV_W'(reps_q);
			end
			DSEL_COMP: begin
				dv_a = DIV_W'(reps_q) * 32'd100;
				dv_b = DIV_W'(ses_reps_q);
			end
			DSEL_AMP: begin
				dv_a = DIV_W'(peak_best_q) * 32'd100;
				dv_b = DIV_W'(ses_tang_q);
			end
			DSEL_PART: begin
				dv_a = DIV_W'(emg_reps_q) * 32'd100;
				dv_b = DIV_W'(reps_q);
			end
			default: ;
		endcase
	end

	// counts and peaks are at most 16 bits, so value*100 stays below 2^23
	rcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dv_a),
		.divisor  (dv_b),
		.busy     (dv_busy),
		.quotient (dv_q)
	);

	assign pct_num     = dv_q;
	assign pct_clamped = (pct_num > 32'd100) ? 7'd100 : pct_num[SCORE_W-1:0];

	logic [13:0] tot_sum;
	logic [26:0] tot_prod;
	assign tot_sum  = 14'(comp_q) * 14'd40 + 14'(amp_q) * 14'd40 + 14'(part_q) * 14'd20;
	assign tot_prod = 27'(tot_sum) * DIV100_RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ses_action_q <= '0;
			ses_reps_q   <= DEF_TARGET_REPS;
			ses_enter_q  <= DEF_ENTER_ANGLE;
			ses_exit_q   <= DEF_EXIT_ANGLE;
			ses_tang_q   <= DEF_TARGET_ANGLE;
			phase_q      <= PH_IDLE;
			reps_q       <= '0;
			peak_now_q   <= '0;
			peak_best_q  <= '0;
			peak_total_q <= '0;
			mean_q       <= '0;
			emg_reps_q   <= '0;
			had_emg_q    <= 1'b0;
			shown_q      <= '0;
			comp_q       <= '0;
			amp_q        <= '0;
			part_q       <= '0;
			tot_q        <= '0;
			rep_done_q   <= 1'b0;
			sess_done_q  <= 1'b0;
		end else begin
			if (cmd.update) begin
				rep_done_q  <= 1'b0;
				sess_done_q <= 1'b0;
				case (func_q)
					FUNC_START: begin
						ses_action_q <= cfg_action_q;
						ses_reps_q   <= (cfg_reps_q == '0) ? DEF_TARGET_REPS : cfg_reps_q;
						ses_tang_q   <= (cfg_tang_q == '0) ? DEF_TARGET_ANGLE : cfg_tang_q;
						ses_enter_q  <= cfg_enter_q;
						ses_exit_q   <= (cfg_exit_s > cfg_enter_s) ?
							{2'b00, cfg_enter_q[14:1]} : cfg_exit_q;
						phase_q      <= PH_WAIT;
						reps_q       <= '0;
						peak_now_q   <= '0;
						peak_best_q  <= '0;
						peak_total_q <= '0;
						mean_q       <= '0;
						emg_reps_q   <= '0;
						had_emg_q    <= 1'b0;
						shown_q      <= '0;
						comp_q       <= '0;
						amp_q        <= '0;
						part_q       <= '0;
						tot_q        <= '0;
					end
					FUNC_STOP: begin
						if (is_live) phase_q <= PH_IDLE;
					end
					FUNC_SAMPLE: begin
						if (is_live) begin
							if (!counted) begin
								shown_q <= sv_q ? ang_q : 16'd0;
							end else begin
								shown_q <= ang_q;
								if (phase_q == PH_WAIT) begin
									if (enter_hit) begin
										phase_q    <= PH_MOVE;
										peak_now_q <= ang_q[14:0];
										had_emg_q  <= emg_q;
									end
								end else if (exit_hit) begin
									// peak update is moot: an exit angle is never above the current peak
									phase_q    <= (32'(reps_inc) >= 32'(ses_reps_q)) ?
										PH_DONE : PH_WAIT;
									sess_done_q <= (32'(reps_inc) >= 32'(ses_reps_q));
									reps_q     <= reps_inc;
									rep_done_q <= 1'b1;
									if (peak_now_q > peak_best_q) peak_best_q <= peak_now_q;
									peak_total_q <= total_sum[TOTAL_W] ? TOTAL_MAX :
										total_sum[TOTAL_W-1:0];
									if ((had_emg_q || emg_q) && emg_reps_q != CNT_MAX)
										emg_reps_q <= emg_reps_q + 1'b1;
									had_emg_q <= 1'b0;
								end else begin
									if (ang_s > peak_s) peak_now_q <= ang_q[14:0];
									if (emg_q) had_emg_q <= 1'b1;
								end
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.div_store) begin
				unique case (cmd.div_sel)
					DSEL_MEAN: mean_q <= dv_q[PEAK_W-1:0];
					DSEL_COMP: comp_q <= pct_clamped;
					DSEL_AMP:  amp_q  <= pct_clamped;
					DSEL_PART: part_q <= (reps_q == '0) ? 7'd0 : pct_clamped;
					default: ;
				endcase
			end
			if (cmd.total) tot_q <= tot_prod[19 +: SCORE_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rep_count     <= reps_q[15:0];
			current_angle <= shown_q;
			rep_peak      <= peak_now_q;
			best_peak     <= peak_best_q;
			mean_peak     <= mean_q;
			reps_pct      <= comp_q;
			ampl_pct      <= amp_q;
			emg_pct       <= part_q;
			overall_pct   <= tot_q;
			phase         <= phase_q;
			rep_done      <= rep_done_q;
			session_done  <= sess_done_q;
		end
	end

	// decided from the request and the state before the update step
	assign status.scores_needed = (func_q == FUNC_SAMPLE) && is_live;
	assign status.mean_needed   = (func_q == FUNC_SAMPLE) && is_live && counted &&
		(phase_q == PH_MOVE) && exit_hit;
	assign status.div_busy      = dv_busy;

endmodule
`default_nettype wire

[design/rcs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rcs_ctrl
// Sequencer: takes a request, runs update, division and total steps, hands result.
// ---------------------------------------------------------------------------
module rcs_ctrl
	import rcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire ctl_status_t status,
	output ctl_cmd_t         cmd
);

	ctl_state_t state_q, state_d;
	logic       started_q;
	logic       ov_q;
	logic       out_free;

	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CTL_IDLE;
			started_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == CTL_IDLE || state_d != state_q) started_q <= 1'b0;
			else if (!started_q) started_q <= 1'b1;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	logic div_phase, div_done;
	assign div_phase = (state_q == CTL_DIV_MEAN) || (state_q == CTL_DIV_COMP) ||
		(state_q == CTL_DIV_AMP) || (state_q == CTL_DIV_PART);
	assign div_done  = div_phase && started_q && !status.div_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE:     if (in_valid) state_d = CTL_UPDATE;
			CTL_UPDATE:   state_d = CTL_OUT;
			CTL_DIV_MEAN: if (div_done) state_d = CTL_DIV_COMP;
			CTL_DIV_COMP: if (div_done) state_d = CTL_DIV_AMP;
			CTL_DIV_AMP:  if (div_done) state_d = CTL_DIV_PART;
			CTL_DIV_PART: if (div_done) state_d = CTL_TOTAL;
			CTL_TOTAL:    state_d = CTL_OUT;
			CTL_OUT:      if (out_free) state_d = CTL_IDLE;
			default:      state_d = CTL_IDLE;
		endcase
		// route after the update step
		if (state_q == CTL_UPDATE) begin
			if (status.mean_needed)        state_d = CTL_DIV_MEAN;
			else if (status.scores_needed) state_d = CTL_DIV_COMP;
		end
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == CTL_IDLE);
		unique case (state_q)
			CTL_UPDATE:   cmd.update = 1'b1;
			CTL_DIV_MEAN: cmd.div_sel = DSEL_MEAN;
			CTL_DIV_COMP: cmd.div_sel = DSEL_COMP;
			CTL_DIV_AMP:  cmd.div_sel = DSEL_AMP;
			CTL_DIV_PART: cmd.div_sel = DSEL_PART;
			CTL_TOTAL:    cmd.total = 1'b1;
			CTL_OUT:      cmd.out_load = out_free;
			default: ;
		endcase
		if (div_phase) begin
			cmd.div_start = !started_q;
			cmd.div_store = div_done;
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

[design/repetition_counter_scorer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// repetition_counter_scorer_top
// Repetition counter with hysteresis thresholds and percentage scoring.
// ---------------------------------------------------------------------------
// Usage: each request on the input channel (func: sample, start, stop)
// gives one result on the output channel. The user is to write registers
// on the cfg channel (index 0..4) only while no request is in flight; the
// block itself does not enforce it. Start copies them into the session.
// Start, stop and ignored samples run the update step and then load the
// result; a sample that is scored also runs the three percentages and the
// total, and one that ends a repetition the mean peak before them, in
// turn through one 32-bit serial divider. One request is handled at a
// time and the next can be taken in the cycle after the result is loaded.
// The result sits in an output register; the next request is accepted
// while it waits, and the block holds only when a second result is due.
// Reset clears session state, phase idle, registers to their defaults.
// ---------------------------------------------------------------------------
module repetition_counter_scorer_top
	import rcs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  func,
	input  wire logic        sample_valid,
	input  wire logic [1:0]  sample_action,
	input  wire logic [15:0] angle,
	input  wire logic        muscle_on,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] rep_count,
	output logic      [15:0] current_angle,
	output logic      [14:0] rep_peak,
	output logic      [14:0] best_peak,
	output logic      [14:0] mean_peak,
	output logic      [6:0]  reps_pct,
	output logic      [6:0]  ampl_pct,
	output logic      [6:0]  emg_pct,
	output logic      [6:0]  overall_pct,
	output logic      [1:0]  phase,
	output logic             rep_done,
	output logic             session_done
);

	ctl_cmd_t    cmd;
	ctl_status_t status;

	assign cfg_ready = 1'b1;

	rcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	rcs_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_ready      (in_ready),
		.in_valid      (in_valid),
		.func          (func),
		.sample_valid  (sample_valid),
		.sample_action (sample_action),
		.angle         (angle),
		.muscle_on     (muscle_on),
		.cfg_fire      (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.rep_count     (rep_count),
		.current_angle (current_angle),
		.rep_peak      (rep_peak),
		.best_peak     (best_peak),
		.mean_peak     (mean_peak),
		.reps_pct      (reps_pct),
		.ampl_pct      (ampl_pct),
		.emg_pct       (emg_pct),
		.overall_pct   (overall_pct),
		.phase         (phase),
		.rep_done      (rep_done),
		.session_done  (session_done)
	);

endmodule
`default_nettype wire

[tb/sv/repetition_counter_scorer_top_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// repetition_counter_scorer_top_tb
// Self-checking bench for the repetition counter and scorer. A short table
// of directed requests is followed by random sessions under several register
// settings; every result is checked field by field against a local model.
// ---------------------------------------------------------------------------
module repetition_counter_scorer_top_tb;
	import rcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 200;
	localparam int ITEMS_PER_PASS = 275;
	localparam int COUNT_MAX      = 65535;

	typedef struct packed {
		logic [15:0] reps;
		logic [15:0] ang;
		logic [14:0] peak;
		logic [14:0] best;
		logic [14:0] mean;
		logic [6:0]  comp;
		logic [6:0]  amp;
		logic [6:0]  part;
		logic [6:0]  tot;
		logic [1:0]  ph;
		logic        rd;
		logic        sd;
	} score_res_t;

	typedef struct packed {
		func_t       f;
		logic        v;
		logic [1:0]  act;
		logic [15:0] ang;
		logic        emg;
		logic        typed;
		phase_t      ph;
	} req_row_t;

	localparam int NDIR = 23;
	localparam req_row_t DIR_TAB [NDIR] = '{
		'{FUNC_STOP,   1'b0, 2'd0, 16'd0,     1'b0, 1'b1, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd3000,  1'b1, 1'b1, PH_IDLE},
		'{FUNC_NONE,   1'b1, 2'd3, 16'hFFFF,  1'b1, 1'b1, PH_IDLE},
		'{FUNC_START,  1'b0, 2'd0, 16'd0,     1'b0, 1'b1, PH_WAIT},
		'{FUNC_SAMPLE, 1'b0, 2'd0, 16'd5000,  1'b1, 1'b1, PH_WAIT},
		'{FUNC_SAMPLE, 1'b1, 2'd2, -16'sd18000, 1'b1, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd2999,  1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd3000,  1'b1, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd18000, 1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd3000,  1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd3001,  1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, -16'sd18000, 1'b0, 1'b0, PH_IDLE},
		'{FUNC_NONE,   1'b0, 2'd0, 16'd0,     1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd5000,  1'b1, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd3000,  1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd4000,  1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd0,     1'b1, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd9000,  1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd100,   1'b0, 1'b0, PH_IDLE},
		'{FUNC_SAMPLE, 1'b1, 2'd0, 16'd9000,  1'b1, 1'b0, PH_IDLE},
		'{FUNC_STOP,   1'b0, 2'd0, 16'd0,     1'b0, 1'b0, PH_IDLE},
		'{FUNC_START,  1'b0, 2'd0, 16'd0,     1'b0, 1'b1, PH_WAIT},
		'{FUNC_STOP,   1'b0, 2'd0, 16'd0,     1'b0, 1'b1, PH_IDLE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = FUNC_SAMPLE;
	logic        sample_valid = 1'b0;
	logic [1:0]  sample_action = 2'd0;
	logic [15:0] angle = 16'd0;
	logic        muscle_on = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] rep_count;
	logic [15:0] current_angle;
	logic [14:0] rep_peak;
	logic [14:0] best_peak;
	logic [14:0] mean_peak;
	logic [6:0]  reps_pct;
	logic [6:0]  ampl_pct;
	logic [6:0]  emg_pct;
	logic [6:0]  overall_pct;
	logic [1:0]  phase;
	logic        rep_done;
	logic        session_done;

	repetition_counter_scorer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .sample_valid(sample_valid), .sample_action(sample_action),
		.angle(angle), .muscle_on(muscle_on),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.rep_count(rep_count), .current_angle(current_angle),
		.rep_peak(rep_peak), .best_peak(best_peak), .mean_peak(mean_peak),
		.reps_pct(reps_pct), .ampl_pct(ampl_pct),
		.emg_pct(emg_pct), .overall_pct(overall_pct),
		.phase(phase), .rep_done(rep_done), .session_done(session_done)
	);

	always #4 clk = ~clk;

	// register copies and the session latched at start
	int reg_act, reg_treps, reg_enter, reg_exit, reg_tang;
	int s_act, s_treps, s_tang, s_enter, s_exit;
	phase_t sess_ph;
	int reps_n, pk_now, pk_best, pk_mean, emg_n, rep_emg, disp_ang;
	longint pk_sum;
	int sc [4];

	score_res_t score_q [$];
	int errors = 0;
	int idle_in = 0;
	int idle_out = 0;
	int quiet_cycles = 0;

	function automatic int pct(longint v, longint t);
		longint r;
		if (t == 0)
			return 0;
		r = (v * 100) / t;
		return (r > 100) ? 100 : int'(r);
	endfunction

	function void clear_session();
		sess_ph = PH_IDLE;
		reps_n = 0; pk_now = 0; pk_best = 0; pk_sum = 0; pk_mean = 0;
		emg_n = 0; rep_emg = 0; disp_ang = 0;
		for (int i = 0; i < 4; i++)
			sc[i] = 0;
	endfunction

	function void model_reset();
		clear_session();
		reg_act = 0; reg_treps = 5; reg_enter = 3000; reg_exit = 3000; reg_tang = 15000;
		s_act = 0; s_treps = 5; s_enter = 3000; s_exit = 3000; s_tang = 15000;
	endfunction

	function void model_cfg(logic [2:0] idx, logic [15:0] d);
		case (idx)
			REG_ACTION:       reg_act = d[1:0];
			REG_TARGET_REPS:  reg_treps = d;
			REG_ENTER_ANGLE:  reg_enter = d[14:0];
			REG_EXIT_ANGLE:   reg_exit = $signed(d);
			REG_TARGET_ANGLE: reg_tang = d;
			default: ;
		endcase
	endfunction

	function score_res_t score_step(logic [1:0] f, logic v, logic [1:0] act,
			logic [15:0] raw, logic emg);
		score_res_t r;
		int a;
		logic rd, sd;
		a = $signed(raw);
		rd = 1'b0;
		sd = 1'b0;
		if (f == FUNC_START) begin
			clear_session();
			s_act = reg_act;
			s_treps = (reg_treps == 0) ? 5 : reg_treps;
			s_tang = (reg_tang == 0) ? 15000 : reg_tang;
			s_enter = reg_enter;
			s_exit = (reg_exit > s_enter) ? s_enter / 2 : reg_exit;
			sess_ph = PH_WAIT;
		end else if (f == FUNC_STOP) begin
			if (sess_ph == PH_WAIT || sess_ph == PH_MOVE)
				sess_ph = PH_IDLE;
		end else if (f == FUNC_SAMPLE && (sess_ph == PH_WAIT || sess_ph == PH_MOVE)) begin
			if (!v || act != s_act) begin
				disp_ang = v ? a : 0;
			end else begin
				disp_ang = a;
				if (sess_ph == PH_WAIT) begin
					if (a >= s_enter) begin
						sess_ph = PH_MOVE;
						pk_now = a & 32'h7FFF;
						rep_emg = emg;
					end
				end else begin
					if (a > pk_now)
						pk_now = a & 32'h7FFF;
					if (emg)
						rep_emg = 1;
					if (a <= s_exit) begin
						sess_ph = PH_WAIT;
						if (reps_n < COUNT_MAX)
							reps_n++;
						rd = 1'b1;
						if (pk_now > pk_best)
							pk_best = pk_now;
						pk_sum += pk_now;
						if (pk_sum > 64'h7FFF_FFFF)
							pk_sum = 64'h7FFF_FFFF;
						pk_mean = int'(pk_sum / reps_n) & 32'h7FFF;
						if (rep_emg && emg_n < COUNT_MAX)
							emg_n++;
						rep_emg = 0;
						if (reps_n >= s_treps) begin
							sess_ph = PH_DONE;
							sd = 1'b1;
						end
					end
				end
			end
			sc[0] = pct(reps_n, s_treps);
			sc[1] = pct(pk_best, s_tang);
			sc[2] = (reps_n == 0) ? 0 : pct(emg_n, reps_n);
			sc[3] = (sc[0] * 40 + sc[1] * 40 + sc[2] * 20) / 100;
		end
		r.reps = reps_n[15:0];
		r.ang = disp_ang[15:0];
		r.peak = pk_now[14:0];
		r.best = pk_best[14:0];
		r.mean = pk_mean[14:0];
		r.comp = sc[0][6:0];
		r.amp = sc[1][6:0];
		r.part = sc[2][6:0];
		r.tot = sc[3][6:0];
		r.ph = sess_ph;
		r.rd = rd;
		r.sd = sd;
		return r;
	endfunction

	task automatic send_req(logic [1:0] f, logic v, logic [1:0] act, logic [15:0] ang,
			logic emg, logic typed, phase_t ph);
		score_res_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_in) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		sample_valid = v;
		sample_action = act;
		angle = ang;
		muscle_on = emg;
		do
			@(posedge clk);
		while (!in_ready);
		r = score_step(f, v, act, ang, emg);
		if (typed) begin
			r = '0;
			r.ph = ph;
		end
		score_q.push_back(r);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] d);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do
			@(posedge clk);
		while (!cfg_ready);
		model_cfg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (score_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic rand_req();
		int r, lo;
		logic [15:0] ang;
		r = $urandom_range(0, 99);
		ang = 16'($signed($urandom_range(0, 36000)) - 18000);
		if (sess_ph == PH_IDLE || sess_ph == PH_DONE) begin
			if (r < 70)
				send_req(FUNC_START, 1'b0, 2'($urandom), ang, 1'($urandom), 1'b0, PH_IDLE);
			else
				send_req(func_t'($urandom_range(0, 3)), 1'($urandom), 2'($urandom), ang,
					1'($urandom), 1'b0, PH_IDLE);
		end else if (r < 3) begin
			send_req(FUNC_START, 1'($urandom), 2'($urandom), ang, 1'($urandom), 1'b0, PH_IDLE);
		end else if (r < 6) begin
			send_req(FUNC_STOP, 1'($urandom), 2'($urandom), ang, 1'($urandom), 1'b0, PH_IDLE);
		end else if (r < 8) begin
			send_req(FUNC_NONE, 1'($urandom), 2'($urandom), ang, 1'($urandom), 1'b0, PH_IDLE);
		end else if (r < 12) begin
			send_req(FUNC_SAMPLE, 1'b0, 2'($urandom), ang, 1'($urandom), 1'b0, PH_IDLE);
		end else if (r < 17) begin
			send_req(FUNC_SAMPLE, 1'b1, 2'(s_act + $urandom_range(1, 3)), ang,
				1'($urandom), 1'b0, PH_IDLE);
		end else begin
			r = $urandom_range(0, 99);
			// steer the angle across the hysteresis band
			if (sess_ph == PH_WAIT && r < 80) begin
				ang = 16'($urandom_range(s_enter, 18000));
			end else if (sess_ph == PH_MOVE && r < 40) begin
				ang = 16'($signed($urandom_range(0, s_exit + 18000)) - 18000);
			end else if (sess_ph == PH_MOVE && r < 80) begin
				lo = (s_exit < -18000) ? -18000 : s_exit;
				ang = 16'($signed($urandom_range(0, 18000 - lo)) + lo);
			end
			send_req(FUNC_SAMPLE, 1'b1, 2'(s_act), ang, 1'($urandom), 1'b0, PH_IDLE);
		end
	endtask

	task automatic chk(string name, int e, int a);
		if (e != a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
		end
	endtask

	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= idle_out);

	always @(posedge clk) begin
		score_res_t e;
		if (out_valid && out_ready) begin
			if (score_q.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, actual rep_count %0d",
					$time, rep_count);
			end else begin
				e = score_q.pop_front();
				chk("rep_count", e.reps, rep_count);
				chk("current_angle", $signed(e.ang), $signed(current_angle));
				chk("rep_peak", e.peak, rep_peak);
				chk("best_peak", e.best, best_peak);
				chk("mean_peak", e.mean, mean_peak);
				chk("reps_pct", e.comp, reps_pct);
				chk("ampl_pct", e.amp, ampl_pct);
				chk("emg_pct", e.part, emg_pct);
				chk("overall_pct", e.tot, overall_pct);
				chk("phase", e.ph, phase);
				chk("rep_done", e.rd, rep_done);
				chk("session_done", e.sd, session_done);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		model_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		idle_in = 29;
		idle_out = 69;
		for (int i = 0; i < NDIR; i++)
			send_req(DIR_TAB[i].f, DIR_TAB[i].v, DIR_TAB[i].act, DIR_TAB[i].ang,
				DIR_TAB[i].emg, DIR_TAB[i].typed, DIR_TAB[i].ph);

		for (int p = 0; p < 6; p++) begin
			drain();
			if (p < 2) begin
				idle_in = 29; idle_out = 69;
			end else if (p < 4) begin
				idle_in = 69; idle_out = 29;
			end else begin
				idle_in = 0; idle_out = 0;
			end
			if (p == 0) begin
				// zero targets, zero enter angle, exit above it: exercise the start-time substitutions
				write_reg(REG_ACTION, 16'($urandom_range(0, 3)));
				write_reg(REG_TARGET_REPS, 16'd0);
				write_reg(REG_ENTER_ANGLE, 16'd0);
				write_reg(REG_EXIT_ANGLE, 16'd18000);
				write_reg(REG_TARGET_ANGLE, 16'd0);
			end else if (p == 1) begin
				write_reg(REG_ACTION, 16'd3);
				write_reg(REG_TARGET_REPS, 16'd65535);
				write_reg(REG_ENTER_ANGLE, 16'd18000);
				write_reg(REG_EXIT_ANGLE, -16'sd18000);
				write_reg(REG_TARGET_ANGLE, 16'd36000);
			end else begin
				write_reg(REG_ACTION, 16'($urandom));
				write_reg(REG_TARGET_REPS, 16'($urandom_range(1, 8)));
				write_reg(REG_ENTER_ANGLE, 16'($urandom_range(0, 18000)));
				write_reg(REG_EXIT_ANGLE, 16'($signed($urandom_range(0, 36000)) - 18000));
				write_reg(REG_TARGET_ANGLE,
					($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 36000)));
				write_reg(3'($urandom_range(5, 7)), 16'($urandom));
			end
			for (int i = 0; i < ITEMS_PER_PASS; i++)
				rand_req();
		end

		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
